// ----- src/gel_pkg.sv -----
// Shared types, constants and the sine/cosine tables of the correlator channel.
// Used by every module of the channel; depends on nothing else.
package gel_pkg;

	localparam int CODE_LENGTH = 1023;
	localparam int CODE_FRAC   = 22;
	localparam int IDX_BITS    = $clog2(CODE_LENGTH);
	localparam int SAMPLE_BITS = 8;
	localparam int PHASE_BITS  = 32;
	localparam int ACC_BITS    = 32;
	localparam int COUNT_BITS  = 24;
	localparam int SPACE_BITS  = 23;
	localparam int LUT_BITS    = 6;
	localparam int LUT_SIZE    = 1 << LUT_BITS;
	localparam int LUT_QUARTER = LUT_SIZE / 4;
	localparam int TRIG_BITS   = 16;
	localparam int TRIG_FRAC   = 14;
	localparam int PROD_BITS   = SAMPLE_BITS + TRIG_BITS;
	localparam int WIPE_BITS   = PROD_BITS + 2 - TRIG_FRAC;

	localparam logic [PHASE_BITS-1:0] CODE_SPAN = PHASE_BITS'(CODE_LENGTH) << CODE_FRAC;
	localparam logic [PHASE_BITS:0]   HALF_CHIP = (PHASE_BITS+1)'(1) << (CODE_FRAC - 1);

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_START  = 2'd1,
		CMD_SAMPLE = 2'd2,
		CMD_DUMP   = 2'd3
	} cmd_t;

	localparam logic [1:0] CFG_CODE_STEP    = 2'd0;
	localparam logic [1:0] CFG_CARRIER_STEP = 2'd1;
	localparam logic [1:0] CFG_CHIP_SPACING = 2'd2;
	localparam logic [1:0] CFG_HALF_COUNT   = 2'd3;

	// accumulator slots, real part at slot, imaginary at slot + 1
	localparam int ACC_EARLY   = 0;
	localparam int ACC_PROMPT1 = 2;
	localparam int ACC_PROMPT2 = 4;
	localparam int ACC_LATE    = 6;

	typedef struct packed {
		cmd_t                          cmd;
		logic                          load_ok;
		logic [IDX_BITS-1:0]           chip_index;
		logic                          chip_value;
		logic [PHASE_BITS-1:0]         code_phase;
		logic [PHASE_BITS-1:0]         carrier_phase;
		logic [COUNT_BITS-1:0]         count;
		logic signed [SAMPLE_BITS-1:0] si;
		logic signed [SAMPLE_BITS-1:0] sq;
	} op_t;

	typedef struct packed {
		logic [PHASE_BITS-1:0] code_step_mod;
		logic [PHASE_BITS-1:0] carrier_step;
		logic [SPACE_BITS-1:0] spacing;
		logic [COUNT_BITS-1:0] half_count;
	} cfg_t;

	typedef struct packed {
		logic [7:0][ACC_BITS-1:0] acc;
		logic [PHASE_BITS-1:0]    code_phase;
		logic [PHASE_BITS-1:0]    carrier_phase;
		logic [COUNT_BITS-1:0]    count;
	} res_t;

	typedef logic signed [TRIG_BITS-1:0] trig_tab_t [LUT_SIZE];

	// sin(pi/2 * m / LUT_QUARTER) in Q14, integer Taylor series
	function automatic longint unsigned quarter_sin(input longint unsigned m);
		longint unsigned one;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		one = 64'd1073741824;
		x   = (64'd3373259426 * m) / (2 * LUT_QUARTER);
		x2  = (x * x) >> 30;
		t   = one;
		t   = one - ((x2 * t) >> 30) / 110;
		t   = one - ((x2 * t) >> 30) / 72;
		t   = one - ((x2 * t) >> 30) / 42;
		t   = one - ((x2 * t) >> 30) / 20;
		t   = one - ((x2 * t) >> 30) / 6;
		return (((x * t) >> 30) + 64'd32768) >> 16;
	endfunction

	function automatic trig_tab_t make_tab(input logic cosine);
		trig_tab_t       tab;
		int              k;
		int              idx;
		int              quad;
		int              r;
		longint unsigned mag;
		for (k = 0; k < LUT_SIZE; k++) begin
			idx  = (k + (cosine ? LUT_QUARTER : 0)) & (LUT_SIZE - 1);
			quad = idx >> (LUT_BITS - 2);
			r    = idx & (LUT_QUARTER - 1);
			mag  = quad[0] ? quarter_sin(64'(LUT_QUARTER - r)) : quarter_sin(64'(r));
			tab[k] = (quad >= 2) ? -TRIG_BITS'(mag) : TRIG_BITS'(mag);
		end
		return tab;
	endfunction

	localparam trig_tab_t SIN_TAB = make_tab(1'b0);
	localparam trig_tab_t COS_TAB = make_tab(1'b1);

	function automatic logic signed [ACC_BITS-1:0] sat_add(
		input logic signed [ACC_BITS-1:0]  a,
		input logic signed [WIPE_BITS-1:0] v,
		input logic                        plus
	);
		logic signed [ACC_BITS:0] d;
		logic signed [ACC_BITS:0] s;
		d = plus ? (ACC_BITS+1)'(v) : -((ACC_BITS+1)'(v));
		s = (ACC_BITS+1)'(a) + d;
		if (s[ACC_BITS] != s[ACC_BITS-1])
			return s[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
		return s[ACC_BITS-1:0];
	endfunction

endpackage

// ----- src/gel_front.sv -----
// Front end: accepts command items, classifies them and queues them for the back end.
// Depends on gel_pkg.
module gel_front import gel_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [1:0]                    command,
	input  logic [9:0]                    chip_index,
	input  logic                          chip_value,
	input  logic [31:0]                   start_code_phase,
	input  logic [31:0]                   start_carrier_phase,
	input  logic [23:0]                   start_count,
	input  logic signed [SAMPLE_BITS-1:0] sample_i,
	input  logic signed [SAMPLE_BITS-1:0] sample_q,
	input  logic                          deq,
	output logic                          head_valid,
	output op_t                           head
);

	localparam int DEPTH = 4;
	localparam int PTR_BITS = $clog2(DEPTH);

	op_t                 op;
	op_t                 q_mem [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [PTR_BITS:0]   cnt_q;
	logic                enq;

	// classify: check the load address, fold the start phase into one code period
	always_comb begin
		op               = '0;
		op.cmd           = cmd_t'(command);
		op.load_ok       = (32'(chip_index) < CODE_LENGTH);
		op.chip_index    = IDX_BITS'(chip_index);
		op.chip_value    = chip_value;
		op.code_phase    = (start_code_phase >= CODE_SPAN) ?
			(start_code_phase - CODE_SPAN) : start_code_phase;
		op.carrier_phase = start_carrier_phase;
		op.count         = start_count;
		op.si            = sample_i;
		op.sq            = sample_q;
	end

	assign full       = (cnt_q == (PTR_BITS+1)'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = q_mem[rd_ptr_q];
	assign enq        = push && !full;

	always_ff @(posedge clk) begin
		if (enq)
			q_mem[wr_ptr_q] <= op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (enq)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (deq)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + (PTR_BITS+1)'(enq) - (PTR_BITS+1)'(deq);
		end
	end

endmodule

// ----- src/gel_back.sv -----
// Back end: chip stores, carrier wipe-off and early/prompt/late accumulation, three stages.
// Depends on gel_pkg.
module gel_back import gel_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic head_valid,
	input  op_t  head,
	output logic deq,
	output logic res_push,
	output res_t res,
	input  logic res_full
);

	// three copies of the code so all three taps read in one cycle
	logic mem_e [CODE_LENGTH];
	logic mem_p [CODE_LENGTH];
	logic mem_l [CODE_LENGTH];

	logic [PHASE_BITS-1:0] code_q;
	logic [PHASE_BITS-1:0] carrier_q;
	logic [COUNT_BITS-1:0] left_q;
	logic signed [ACC_BITS-1:0] acc_q [8];

	logic adv;
	logic act;

	logic [PHASE_BITS:0]   e_sum;
	logic [PHASE_BITS:0]   p_sum;
	logic signed [PHASE_BITS+1:0] l_sum;
	logic [PHASE_BITS-CODE_FRAC:0]          e_raw;
	logic [PHASE_BITS-CODE_FRAC:0]          p_raw;
	logic signed [PHASE_BITS-CODE_FRAC+1:0] l_raw;
	logic [IDX_BITS-1:0] e_idx;
	logic [IDX_BITS-1:0] p_idx;
	logic [IDX_BITS-1:0] l_idx;
	logic [PHASE_BITS:0] code_nxt;
	logic [LUT_BITS-1:0] lut_a;

	// stage 1
	logic                          v_s1;
	cmd_t                          cmd_s1;
	logic [IDX_BITS-1:0]           e_idx_s1, p_idx_s1, l_idx_s1;
	logic signed [TRIG_BITS-1:0]   c_s1, s_s1;
	logic signed [SAMPLE_BITS-1:0] si_s1, sq_s1;
	logic                          second_s1;
	logic [PHASE_BITS-1:0]         code_s1, carrier_s1;
	logic [COUNT_BITS-1:0]         left_s1;

	// stage 2
	logic                        v_s2;
	cmd_t                        cmd_s2;
	logic                        ce_s2, cp_s2, cl_s2;
	logic signed [PROD_BITS-1:0] p_ic_s2, p_qs_s2, p_qc_s2, p_is_s2;
	logic                        second_s2;
	logic [PHASE_BITS-1:0]       code_s2, carrier_s2;
	logic [COUNT_BITS-1:0]       left_s2;

	// stage 3
	logic                        v_s3;
	cmd_t                        cmd_s3;
	logic                        ce_s3, cp_s3, cl_s3;
	logic signed [WIPE_BITS-1:0] re_s3, im_s3;
	logic                        second_s3;
	logic [PHASE_BITS-1:0]       code_s3, carrier_s3;
	logic [COUNT_BITS-1:0]       left_s3;

	logic signed [PROD_BITS+1:0] re_w, im_w;
	logic [2:0]                  pslot;

	assign adv = !(v_s3 && cmd_s3 == CMD_DUMP && res_full);
	assign deq = adv && head_valid;
	// a sample with nothing left to integrate is dropped here
	assign act = deq && !(head.cmd == CMD_SAMPLE && left_q == '0);

	// tap indices, each wrapped once into the code period
	always_comb begin
		e_sum = {1'b0, code_q} + (PHASE_BITS+1)'(cfg.spacing) + HALF_CHIP;
		p_sum = {1'b0, code_q} + HALF_CHIP;
		l_sum = $signed({2'b00, code_q}) - $signed((PHASE_BITS+2)'(cfg.spacing))
			+ $signed({1'b0, HALF_CHIP});
		e_raw = e_sum[PHASE_BITS:CODE_FRAC];
		p_raw = p_sum[PHASE_BITS:CODE_FRAC];
		l_raw = l_sum[PHASE_BITS+1:CODE_FRAC];
		e_idx = (32'(e_raw) >= CODE_LENGTH) ?
			IDX_BITS'(32'(e_raw) - CODE_LENGTH) : IDX_BITS'(e_raw);
		p_idx = (32'(p_raw) >= CODE_LENGTH) ?
			IDX_BITS'(32'(p_raw) - CODE_LENGTH) : IDX_BITS'(p_raw);
		if (l_raw < 0)
			l_idx = IDX_BITS'(32'(l_raw) + CODE_LENGTH);
		else if (32'(l_raw) >= CODE_LENGTH)
			l_idx = IDX_BITS'(32'(l_raw) - CODE_LENGTH);
		else
			l_idx = IDX_BITS'(l_raw);
		code_nxt = {1'b0, code_q} + {1'b0, cfg.code_step_mod};
		if (code_nxt >= {1'b0, CODE_SPAN})
			code_nxt = code_nxt - {1'b0, CODE_SPAN};
		lut_a = carrier_q[PHASE_BITS-1 -: LUT_BITS];
	end

	always_ff @(posedge clk) begin
		if (deq && head.cmd == CMD_LOAD && head.load_ok) begin
			mem_e[head.chip_index] <= head.chip_value;
			mem_p[head.chip_index] <= head.chip_value;
			mem_l[head.chip_index] <= head.chip_value;
		end
	end

	// channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q    <= '0;
			carrier_q <= '0;
			left_q    <= '0;
		end else if (deq) begin
			case (head.cmd)
				CMD_START: begin
					code_q    <= head.code_phase;
					carrier_q <= head.carrier_phase;
					left_q    <= head.count;
				end
				CMD_SAMPLE: begin
					if (left_q != '0) begin
						code_q    <= code_nxt[PHASE_BITS-1:0];
						carrier_q <= carrier_q + cfg.carrier_step;
						left_q    <= left_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= act;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1     <= head.cmd;
			e_idx_s1   <= e_idx;
			p_idx_s1   <= p_idx;
			l_idx_s1   <= l_idx;
			c_s1       <= COS_TAB[lut_a];
			s_s1       <= SIN_TAB[lut_a];
			si_s1      <= head.si;
			sq_s1      <= head.sq;
			second_s1  <= !(left_q > cfg.half_count);
			code_s1    <= code_q;
			carrier_s1 <= carrier_q;
			left_s1    <= left_q;

			cmd_s2     <= cmd_s1;
			ce_s2      <= mem_e[e_idx_s1];
			cp_s2      <= mem_p[p_idx_s1];
			cl_s2      <= mem_l[l_idx_s1];
			p_ic_s2    <= si_s1 * c_s1;
			p_qs_s2    <= sq_s1 * s_s1;
			p_qc_s2    <= sq_s1 * c_s1;
			p_is_s2    <= si_s1 * s_s1;
			second_s2  <= second_s1;
			code_s2    <= code_s1;
			carrier_s2 <= carrier_s1;
			left_s2    <= left_s1;

			cmd_s3     <= cmd_s2;
			ce_s3      <= ce_s2;
			cp_s3      <= cp_s2;
			cl_s3      <= cl_s2;
			re_s3      <= re_w[PROD_BITS+1:TRIG_FRAC];
			im_s3      <= im_w[PROD_BITS+1:TRIG_FRAC];
			second_s3  <= second_s2;
			code_s3    <= code_s2;
			carrier_s3 <= carrier_s2;
			left_s3    <= left_s2;
		end
	end

	// round to integer: add half, floor shift
	always_comb begin
		re_w = (PROD_BITS+2)'(p_ic_s2) + (PROD_BITS+2)'(p_qs_s2)
			+ (PROD_BITS+2)'(1 << (TRIG_FRAC - 1));
		im_w = (PROD_BITS+2)'(p_qc_s2) - (PROD_BITS+2)'(p_is_s2)
			+ (PROD_BITS+2)'(1 << (TRIG_FRAC - 1));
		pslot = second_s3 ? 3'(ACC_PROMPT2) : 3'(ACC_PROMPT1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 8; k++)
				acc_q[k] <= '0;
		end else if (adv && v_s3) begin
			case (cmd_s3)
				CMD_START: begin
					for (int k = 0; k < 8; k++)
						acc_q[k] <= '0;
				end
				CMD_SAMPLE: begin
					acc_q[ACC_EARLY]     <= sat_add(acc_q[ACC_EARLY], re_s3, ce_s3);
					acc_q[ACC_EARLY+1]   <= sat_add(acc_q[ACC_EARLY+1], im_s3, ce_s3);
					acc_q[ACC_LATE]      <= sat_add(acc_q[ACC_LATE], re_s3, cl_s3);
					acc_q[ACC_LATE+1]    <= sat_add(acc_q[ACC_LATE+1], im_s3, cl_s3);
					acc_q[pslot]         <= sat_add(acc_q[pslot], re_s3, cp_s3);
					acc_q[pslot + 3'd1]  <= sat_add(acc_q[pslot + 3'd1], im_s3, cp_s3);
				end
				default: ;
			endcase
		end
	end

	assign res_push = adv && v_s3 && (cmd_s3 == CMD_DUMP);

	always_comb begin
		for (int k = 0; k < 8; k++)
			res.acc[k] = acc_q[k];
		res.code_phase    = code_s3;
		res.carrier_phase = carrier_s3;
		res.count         = left_s3;
	end

endmodule

// ----- src/gel_res_fifo.sv -----
// Two-entry result queue that parts the back end from the result port.
// Depends on gel_pkg.
module gel_res_fifo import gel_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  res_t wdata,
	output logic full,
	input  logic rd,
	output logic empty,
	output res_t rdata
);

	res_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_rd;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rd_ptr_q];
	assign do_rd = rd && !empty;

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_rd)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(do_rd);
		end
	end

endmodule

// ----- src/gnss_epl_correlator.sv -----
// Top level of the early/prompt/late correlator channel: config registers, front, back, results.
// Depends on gel_pkg, gel_front, gel_back and gel_res_fifo.
//
//   channel   handshake             payload
//   --------  --------------------  -------------------------------------------------
//   command   push / full           command, chip_index, chip_value, start_*, sample_*
//   result    empty / pop           early_*, prompt_first_*, prompt_second_*, late_*,
//                                   code_phase_now, carrier_phase_now, count_left
//   config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle sustained while no dump waits on a full result queue; a dump result passes
// the command queue, the three-stage back end (chip read, multiply, accumulate) and the result queue.
// Reset clears queues, phases, count and accumulators; the chip stores hold garbage until loaded.
// A full result queue stalls the back end, which then backs up into the command queue.
module gnss_epl_correlator import gel_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	// command side
	input  logic                          push,
	output logic                          full,
	input  logic [1:0]                    command,
	input  logic [9:0]                    chip_index,
	input  logic                          chip_value,
	input  logic [31:0]                   start_code_phase,
	input  logic [31:0]                   start_carrier_phase,
	input  logic [23:0]                   start_count,
	input  logic signed [SAMPLE_BITS-1:0] sample_i,
	input  logic signed [SAMPLE_BITS-1:0] sample_q,
	// result side
	output logic                          empty,
	input  logic                          pop,
	output logic signed [31:0]            early_i,
	output logic signed [31:0]            early_q,
	output logic signed [31:0]            prompt_first_i,
	output logic signed [31:0]            prompt_first_q,
	output logic signed [31:0]            prompt_second_i,
	output logic signed [31:0]            prompt_second_q,
	output logic signed [31:0]            late_i,
	output logic signed [31:0]            late_q,
	output logic [31:0]                   code_phase_now,
	output logic [31:0]                   carrier_phase_now,
	output logic [23:0]                   count_left,
	// configuration
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [31:0]                   cfg_data
);

	cfg_t cfg_q;
	logic head_valid;
	op_t  head;
	logic deq;
	logic res_push;
	res_t res_in;
	res_t res_out;
	logic res_full;

	// config writes are always taken
	assign cfg_ready = 1'b1;

	// code step is stored already folded into one code period
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.code_step_mod <= 32'd4194304;
			cfg_q.carrier_step  <= '0;
			cfg_q.spacing       <= 23'd2097152;
			cfg_q.half_count    <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CODE_STEP:
					cfg_q.code_step_mod <= (cfg_data >= CODE_SPAN) ?
						(cfg_data - CODE_SPAN) : cfg_data;
				CFG_CARRIER_STEP: cfg_q.carrier_step <= cfg_data;
				CFG_CHIP_SPACING: cfg_q.spacing      <= cfg_data[SPACE_BITS-1:0];
				CFG_HALF_COUNT:   cfg_q.half_count   <= cfg_data[COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	gel_front u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.push                (push),
		.full                (full),
		.command             (command),
		.chip_index          (chip_index),
		.chip_value          (chip_value),
		.start_code_phase    (start_code_phase),
		.start_carrier_phase (start_carrier_phase),
		.start_count         (start_count),
		.sample_i            (sample_i),
		.sample_q            (sample_q),
		.deq                 (deq),
		.head_valid          (head_valid),
		.head                (head)
	);

	gel_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.deq        (deq),
		.res_push   (res_push),
		.res        (res_in),
		.res_full   (res_full)
	);

	gel_res_fifo u_res (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.rd     (pop),
		.empty  (empty),
		.rdata  (res_out)
	);

	// unpack the head result onto the ports
	assign early_i           = $signed(res_out.acc[ACC_EARLY]);
	assign early_q           = $signed(res_out.acc[ACC_EARLY+1]);
	assign prompt_first_i    = $signed(res_out.acc[ACC_PROMPT1]);
	assign prompt_first_q    = $signed(res_out.acc[ACC_PROMPT1+1]);
	assign prompt_second_i   = $signed(res_out.acc[ACC_PROMPT2]);
	assign prompt_second_q   = $signed(res_out.acc[ACC_PROMPT2+1]);
	assign late_i            = $signed(res_out.acc[ACC_LATE]);
	assign late_q            = $signed(res_out.acc[ACC_LATE+1]);
	assign code_phase_now    = res_out.code_phase;
	assign carrier_phase_now = res_out.carrier_phase;
	assign count_left        = res_out.count;

endmodule

// ----- src/gel_checker.sv -----
// Port-level checks for the correlator channel, bound to the top level.
// Depends on gel_pkg and gnss_epl_correlator.
module gel_checker import gel_pkg::*; (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          full,
	input logic                          empty,
	input logic                          pop,
	input logic signed [31:0]            early_i,
	input logic signed [31:0]            late_q,
	input logic [23:0]                   count_left,
	input logic                          cfg_ready
);

	// reset leaves both queues empty
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> (empty && !full))
		else $error("queues not empty in reset");

	// a waiting result holds until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(early_i) && $stable(late_q)
			&& $stable(count_left)))
		else $error("waiting result changed");

	// config port never back-pressures
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port not ready");

	// the shortest path from push to result keeps the result side empty right after reset
	a_no_instant: assert property (@(posedge clk) $rose(arst_n) |-> empty [*4])
		else $error("result appeared too early");

endmodule

bind gnss_epl_correlator gel_checker u_gel_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.full       (full),
	.empty      (empty),
	.pop        (pop),
	.early_i    (early_i),
	.late_q     (late_q),
	.count_left (count_left),
	.cfg_ready  (cfg_ready)
);

// ----- bench/gnss_epl_correlator_tb.sv -----
// Self-checking bench for the early/prompt/late correlator channel.
// Drives command items through push/full, pops dump results and compares them with an
// in-bench model of the channel. Depends on gel_pkg and the correlator RTL.
`timescale 1ns / 1ps

module gnss_epl_correlator_tb;
	import gel_pkg::*;

	localparam longint SPAN       = 64'(CODE_LENGTH) << CODE_FRAC;
	localparam int     SETTLE_CYC = 40;
	// integrations start inside the first WIN_CHIPS chips and move at most one chip a sample
	localparam int     WIN_CHIPS  = 64;
	localparam int     LOW_CHIPS  = 96;
	localparam int     HIGH_CHIPS = 32;

	// one dump result, fields in port order
	typedef struct {
		logic [7:0][31:0] acc;
		logic [31:0]      code_ph;
		logic [31:0]      carr_ph;
		logic [23:0]      left;
	} dump_t;

	// one directed row: command fields plus an optional typed-in result
	typedef struct {
		cmd_t        cmd;
		logic [9:0]  idx;
		logic        val;
		logic [31:0] cph;
		logic [31:0] kph;
		logic [23:0] cnt;
		logic [7:0]  si;
		logic [7:0]  sq;
		bit          typed;
		logic [31:0] typed_acc0;
		logic [23:0] typed_left;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic push = 1'b0;
	logic full;
	logic [1:0] command = CMD_LOAD;
	logic [9:0] chip_index = '0;
	logic chip_value = 1'b0;
	logic [31:0] start_code_phase = '0;
	logic [31:0] start_carrier_phase = '0;
	logic [23:0] start_count = '0;
	logic signed [7:0] sample_i = '0;
	logic signed [7:0] sample_q = '0;
	logic empty;
	logic pop = 1'b0;
	logic signed [31:0] early_i, early_q, prompt_first_i, prompt_first_q;
	logic signed [31:0] prompt_second_i, prompt_second_q, late_i, late_q;
	logic [31:0] code_phase_now, carrier_phase_now;
	logic [23:0] count_left;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = CFG_CODE_STEP;
	logic [31:0] cfg_data = '0;

	gnss_epl_correlator i_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// channel model state
	logic [31:0] m_code_step, m_carr_step;
	logic [22:0] m_spacing;
	logic [23:0] m_half;
	logic [31:0] m_code_ph, m_carr_ph;
	logic [23:0] m_left;
	longint      m_acc [8];
	bit          chip_mem [CODE_LENGTH];
	int          sin_q14 [LUT_SIZE];
	int          cos_q14 [LUT_SIZE];

	dump_t expected_dumps [$];
	int    errors = 0;
	bit    stim_done = 0;
	bit    hold_pop = 0;

	// quarter-wave sine, Q14, same integer series the channel is specified with
	function automatic longint qsin(longint unsigned m);
		longint unsigned x, x2, t;
		longint unsigned one;
		one = 64'd1073741824;
		x = (64'd3373259426 * m) / (2 * LUT_QUARTER);
		x2 = (x * x) >> 30;
		t = one;
		t = one - ((x2 * t) >> 30) / 110;
		t = one - ((x2 * t) >> 30) / 72;
		t = one - ((x2 * t) >> 30) / 42;
		t = one - ((x2 * t) >> 30) / 20;
		t = one - ((x2 * t) >> 30) / 6;
		return longint'((((x * t) >> 30) + 64'd32768) >> 16);
	endfunction

	function automatic int sine_at(int k);
		int q, r;
		longint mag;
		k = k & (LUT_SIZE - 1);
		q = k / LUT_QUARTER;
		r = k % LUT_QUARTER;
		mag = (q & 1) ? qsin(LUT_QUARTER - r) : qsin(r);
		return (q >= 2) ? -int'(mag) : int'(mag);
	endfunction

	function automatic longint clamp32(longint a);
		if (a > 64'sd2147483647) return 64'sd2147483647;
		if (a < -64'sd2147483648) return -64'sd2147483648;
		return a;
	endfunction

	// floor((x + 2^13) / 2^14)
	function automatic longint round14(longint x);
		return (x + 8192) >>> 14;
	endfunction

	function automatic int chip_slot(longint unsigned ph);
		return int'(((ph + (64'd1 << 21)) >> 22) % CODE_LENGTH);
	endfunction

	task automatic add_to(int slot, int ci, longint re, longint im);
		if (!chip_mem[ci]) begin
			re = -re;
			im = -im;
		end
		m_acc[slot]     = clamp32(m_acc[slot] + re);
		m_acc[slot + 1] = clamp32(m_acc[slot + 1] + im);
	endtask

	task automatic model_reset();
		for (int k = 0; k < LUT_SIZE; k++) begin
			sin_q14[k] = sine_at(k);
			cos_q14[k] = sine_at(k + LUT_QUARTER);
		end
		m_code_step = 32'd4194304;
		m_carr_step = '0;
		m_spacing = 23'd2097152;
		m_half = '0;
		m_code_ph = '0;
		m_carr_ph = '0;
		m_left = '0;
		foreach (m_acc[k]) m_acc[k] = 0;
	endtask

	// advance the model by one command item; queue a dump result when one comes out
	task automatic correlate(row_t r);
		longint si, sq, c, s, re, im;
		longint unsigned ph;
		int a;
		dump_t d;
		case (r.cmd)
			CMD_LOAD: begin
				if (r.idx < CODE_LENGTH)
					chip_mem[r.idx] = r.val;
			end
			CMD_START: begin
				m_code_ph = 32'(r.cph % SPAN);
				m_carr_ph = r.kph;
				m_left = r.cnt;
				foreach (m_acc[k]) m_acc[k] = 0;
			end
			CMD_SAMPLE: begin
				if (m_left != 0) begin
					si = longint'($signed(r.si));
					sq = longint'($signed(r.sq));
					a = int'(m_carr_ph >> (32 - LUT_BITS));
					c = cos_q14[a];
					s = sin_q14[a];
					re = round14(si * c + sq * s);
					im = round14(sq * c - si * s);
					ph = m_code_ph;
					add_to(ACC_EARLY, chip_slot(ph + m_spacing), re, im);
					add_to(ACC_LATE, chip_slot(ph + SPAN - m_spacing), re, im);
					add_to(m_left > m_half ? ACC_PROMPT1 : ACC_PROMPT2, chip_slot(ph), re, im);
					ph = ph + (m_code_step % SPAN);
					if (ph >= SPAN) ph = ph - SPAN;
					m_code_ph = ph[31:0];
					m_carr_ph = m_carr_ph + m_carr_step;
					m_left = m_left - 24'd1;
				end
			end
			default: begin
				for (int k = 0; k < 8; k++) d.acc[k] = m_acc[k][31:0];
				d.code_ph = m_code_ph;
				d.carr_ph = m_carr_ph;
				d.left = m_left;
				if (r.typed && (d.acc[0] !== r.typed_acc0 || d.left !== r.typed_left)) begin
					$display("%0t: typed-in dump disagrees with model: acc0 %h/%h left %0d/%0d",
						$time, r.typed_acc0, d.acc[0], r.typed_left, d.left);
					errors++;
				end
				expected_dumps.push_back(d);
			end
		endcase
	endtask

	// hold the item until the queue takes it
	task automatic send(row_t r);
		push <= 1'b1;
		command <= r.cmd;
		chip_index <= r.idx;
		chip_value <= r.val;
		start_code_phase <= r.cph;
		start_carrier_phase <= r.kph;
		start_count <= r.cnt;
		sample_i <= r.si;
		sample_q <= r.sq;
		do @(posedge clk); while (full);
		correlate(r);
	endtask

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if (n > 0) begin
			push <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// only while the channel is quiet
	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		push <= 1'b0;
		wait (expected_dumps.size() == 0);
		repeat (SETTLE_CYC) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_CODE_STEP:    m_code_step = data;
			CFG_CARRIER_STEP: m_carr_step = data;
			CFG_CHIP_SPACING: m_spacing = data[22:0];
			default:          m_half = data[23:0];
		endcase
	endtask

	function automatic row_t mk(cmd_t c);
		row_t r;
		r.cmd = c;
		r.idx = 10'($urandom_range(0, CODE_LENGTH - 1));
		r.val = 1'($urandom_range(0, 1));
		r.cph = $urandom;
		r.kph = $urandom;
		r.cnt = 24'($urandom_range(1, 40));
		r.si = 8'($urandom);
		r.sq = 8'($urandom);
		r.typed = 0;
		r.typed_acc0 = '0;
		r.typed_left = '0;
		return r;
	endfunction

	// load the chips at both ends of the code; integrations below stay within them
	task automatic load_code();
		row_t r;
		for (int k = 0; k < CODE_LENGTH; k++) begin
			if (k < LOW_CHIPS || k >= CODE_LENGTH - HIGH_CHIPS) begin
				r = mk(CMD_LOAD);
				r.idx = 10'(k);
				send(r);
				if ($urandom_range(0, 15) == 0) idle_gap();
			end
		end
	endtask

	// one integration: start, a run of samples, a dump, with random noise items between
	task automatic integrate(int len, bit extreme);
		row_t r;
		r = mk(CMD_START);
		r.cnt = 24'(len);
		r.cph = $urandom_range(0, WIN_CHIPS << CODE_FRAC);
		send(r);
		idle_gap();
		for (int k = 0; k < len + 2; k++) begin
			r = mk(CMD_SAMPLE);
			if (extreme) begin
				r.si = ($urandom_range(0, 1)) ? 8'h80 : 8'h7f;
				r.sq = ($urandom_range(0, 1)) ? 8'h80 : 8'h7f;
			end
			if ($urandom_range(0, 19) == 0) r = mk(CMD_LOAD);
			send(r);
			idle_gap();
		end
		send(mk(CMD_DUMP));
	endtask

	// at most one chip a sample, forward or backward
	function automatic logic [31:0] rand_code_step();
		if ($urandom_range(0, 1))
			return 32'($urandom_range(0, 1 << CODE_FRAC));
		return 32'(SPAN - longint'($urandom_range(1, 1 << CODE_FRAC)));
	endfunction

	row_t dir [$];

	initial begin
		row_t r;
		model_reset();
		#1 arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows; dump after reset, dump of an empty start and dump of a maximum-count start are typed in
		r = mk(CMD_DUMP); r.typed = 1; dir.push_back(r);
		r = mk(CMD_LOAD); r.idx = 10'd1023; dir.push_back(r); // out-of-range load, dropped
		r = mk(CMD_LOAD); r.idx = 10'd0; r.val = 1; dir.push_back(r);
		r = mk(CMD_LOAD); r.idx = 10'd1022; r.val = 0; dir.push_back(r);
		r = mk(CMD_SAMPLE); dir.push_back(r);                 // sample while idle, dropped
		r = mk(CMD_START); r.cnt = 0; r.cph = 32'hffff_ffff; dir.push_back(r);
		r = mk(CMD_DUMP); r.typed = 1; dir.push_back(r);
		r = mk(CMD_START); r.cnt = 24'hff_ffff; r.cph = 32'hffc0_0000; dir.push_back(r);
		r = mk(CMD_DUMP); r.typed = 1; r.typed_left = 24'hff_ffff; dir.push_back(r);
		foreach (dir[k]) send(dir[k]);
		push <= 1'b0;

		// every chip a sample can reach must be written before it is read
		load_code();

		write_reg(CFG_CODE_STEP, 32'hffff_ffff);
		write_reg(CFG_CARRIER_STEP, 32'hffff_ffff);
		write_reg(CFG_CHIP_SPACING, 32'd4194304);
		write_reg(CFG_HALF_COUNT, 32'd4);
		integrate(10, 1);
		write_reg(CFG_CHIP_SPACING, 32'd0);
		write_reg(CFG_CODE_STEP, 32'd0);
		write_reg(CFG_HALF_COUNT, 32'hff_ffff);
		integrate(6, 1);

		for (int ph = 0; ph < 5; ph++) begin
			write_reg(CFG_CODE_STEP, rand_code_step());
			write_reg(CFG_CARRIER_STEP, $urandom);
			write_reg(CFG_CHIP_SPACING, $urandom_range(0, 4194304));
			write_reg(CFG_HALF_COUNT, $urandom_range(0, 20));
			if (ph == 3) hold_pop = 1;
			for (int j = 0; j < 8; j++) integrate($urandom_range(0, 12), $urandom_range(0, 3) == 0);
		end
		push <= 1'b0;
		stim_done = 1;
	end

	// receiver: random stalls, plus one long hold-off so the queues back up
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_pop) begin
				hold_pop = 0;
				pop <= 1'b0;
				repeat (400) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
			if ($urandom_range(0, 3) == 0) n = 0;
			if (n > 0) begin
				pop <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	// compare every accepted result with the oldest expected dump
	always @(posedge clk) begin
		dump_t d;
		logic [7:0][31:0] got;
		if (arst_n && pop && !empty) begin
			got = {late_q, late_i, prompt_second_q, prompt_second_i,
				prompt_first_q, prompt_first_i, early_q, early_i};
			if (expected_dumps.size() == 0) begin
				$display("%0t: result with nothing expected", $time);
				errors++;
			end else begin
				d = expected_dumps.pop_front();
				for (int k = 0; k < 8; k++)
					if (got[k] !== d.acc[k]) begin
						$display("%0t: acc %0d expected %h actual %h", $time, k, d.acc[k], got[k]);
						errors++;
					end
				if (code_phase_now !== d.code_ph) begin
					$display("%0t: code phase expected %h actual %h", $time, d.code_ph, code_phase_now);
					errors++;
				end
				if (carrier_phase_now !== d.carr_ph) begin
					$display("%0t: carrier phase expected %h actual %h",
						$time, d.carr_ph, carrier_phase_now);
					errors++;
				end
				if (count_left !== d.left) begin
					$display("%0t: count expected %0d actual %0d", $time, d.left, count_left);
					errors++;
				end
			end
		end
	end

	// wind down once everything is in and drained
	initial begin
		wait (stim_done);
		wait (expected_dumps.size() == 0);
		repeat (SETTLE_CYC) @(posedge clk);
		if (errors == 0 && expected_dumps.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#4000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
